FILE: hdl/box_blur_3x3_stream_defines.svh
// Assertion macros for the box blur stream checker.
// Depends on clk and rst_n being visible where a macro is used.
`ifndef BOX_BLUR_3X3_STREAM_DEFINES_SVH
`define BOX_BLUR_3X3_STREAM_DEFINES_SVH

// Check cons in the same cycle as ante.
`define BB3_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define BB3_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/bb3_pkg.sv
// Shared types and constants for the 3x3 box blur stream.
// No dependencies; used by the lanes, the output stage and the top level.
package bb3_pkg;

    // Per-channel arithmetic widths
    typedef logic [7:0]  pix_t;
    typedef logic [11:0] sum_t;    // up to 9 * 255
    typedef logic [3:0]  cnt_t;    // 1 to 9 neighbors
    typedef logic [12:0] divd_t;   // 2*sum + count
    typedef logic [4:0]  divs_t;   // 2*count
    typedef logic [2:0]  step_t;   // quotient bit position

    // One channel of the 3x3 window, entry row*3+col
    typedef logic [8:0][7:0] chan_win_t;

    // Quotients of the red, green and blue lanes
    typedef logic [2:0][7:0] quot_set_t;

    // Control handed from the sequencer to every lane
    typedef struct packed {
        logic       start;
        logic [8:0] mask;
    } lane_ctl_t;

    // Configuration register indexes (paddr bit 2)
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // Register reset values
    localparam logic [10:0] FRAME_WIDTH_RST  = 11'd640;
    localparam logic [12:0] FRAME_HEIGHT_RST = 13'd480;

endpackage

FILE: hdl/box_blur_3x3_stream.sv
// Top level of the 3x3 box blur stream: sequencer, counters, window and APB registers.
// Depends on bb3_pkg, bb3_line_store, bb3_lane and bb3_merge.
//
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------------------
//  pixel   | pix_valid/pix_ready  | mode, red_in, green_in, blue_in
//  result  | res_valid/res_ready  | red_out, green_out, blue_out, row_end, frame_end
//  config  | psel/penable/pwrite  | paddr, pwdata, prdata (pready tied high)
//
// A pixel or drain transaction that releases no result passes through S_IDLE and S_WIN; each
// result it releases adds a load, an 8-step divide in the three color lanes and a push.
// A transaction whose mode does not match the frame phase is taken and dropped.
// Reset brings width 640, height 480 and the start of a frame; line buffers are not cleared.
// A stalled result port holds one result; the next result waits for its slot.
module box_blur_3x3_stream #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    // pixel channel
    input  logic        pix_valid,
    output logic        pix_ready,
    input  logic        mode,
    input  logic [7:0]  red_in,
    input  logic [7:0]  green_in,
    input  logic [7:0]  blue_in,
    // result channel
    output logic        res_valid,
    input  logic        res_ready,
    output logic [7:0]  red_out,
    output logic [7:0]  green_out,
    output logic [7:0]  blue_out,
    output logic        row_end,
    output logic        frame_end,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_WIN  = 5'b00010,
        S_LOAD = 5'b00100,
        S_DIV  = 5'b01000,
        S_PUSH = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [10:0]   frame_width_reg;
    logic [12:0]   frame_height_reg;
    logic [CW-1:0] col_pos_reg;
    logic [HW-1:0] row_pos_reg;
    logic [WW-1:0] used_w;
    logic [HW-1:0] used_h;

    logic [23:0]   win_reg [3][3];
    logic [23:0]   pix_reg;
    logic          drain_reg;
    logic          emit_a_reg;
    logic          emit_b_reg;
    logic          top_ok_reg;
    logic          bot_ok_reg;
    logic          left2_reg;
    logic          left1_reg;
    logic          cur_b_reg;

    logic          cfg_wr;
    logic          pix_acc;
    logic          item_ok;
    logic          drain;
    logic          last_col;
    logic          r_ge1;
    logic          r_ge2;
    logic          c_ge1;
    logic          c_ge2;
    logic [23:0]   upper_rd;
    logic [23:0]   middle_rd;
    logic [2:0]    row_m;
    logic [2:0]    col_m;
    logic          space;
    logic          push;

    bb3_pkg::lane_ctl_t lane_ctl;
    bb3_pkg::quot_set_t lane_quot;
    logic [2:0]         lane_idle;

    // Configuration writes and reads
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_comb
    begin
        unique case (paddr[2])
            bb3_pkg::REG_FRAME_HEIGHT: prdata = {19'b0, frame_height_reg};
            default:                   prdata = {21'b0, frame_width_reg};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= bb3_pkg::FRAME_WIDTH_RST;
            frame_height_reg <= bb3_pkg::FRAME_HEIGHT_RST;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == bb3_pkg::REG_FRAME_HEIGHT)
            begin
                frame_height_reg <= pwdata[12:0];
            end
            else
            begin
                frame_width_reg <= pwdata[10:0];
            end
        end
    end

    // Clamp the frame size to 1..MAX
    always_comb
    begin
        if (frame_width_reg == '0)
        begin
            used_w = WW'(1);
        end
        else if (32'(frame_width_reg) > 32'(MAX_WIDTH))
        begin
            used_w = WW'(MAX_WIDTH);
        end
        else
        begin
            used_w = WW'(frame_width_reg);
        end
    end

    always_comb
    begin
        if (frame_height_reg == '0)
        begin
            used_h = HW'(1);
        end
        else if (32'(frame_height_reg) > 32'(MAX_HEIGHT))
        begin
            used_h = HW'(MAX_HEIGHT);
        end
        else
        begin
            used_h = HW'(frame_height_reg);
        end
    end

    // Position flags
    assign drain    = row_pos_reg >= used_h;
    assign last_col = (WW'(col_pos_reg) + WW'(1)) == used_w;
    assign r_ge1    = row_pos_reg != '0;
    assign r_ge2    = row_pos_reg > HW'(1);
    assign c_ge1    = col_pos_reg != '0;
    assign c_ge2    = col_pos_reg > CW'(1);

    // Take a transaction when idle; keep it only if it matches the frame phase
    assign pix_ready = state_reg == S_IDLE;
    assign pix_acc   = pix_valid && pix_ready;
    assign item_ok   = pix_acc && (mode == drain);

    always_ff @(posedge clk)
    begin
        if (item_ok)
        begin
            pix_reg   <= drain ? 24'b0 : {red_in, green_in, blue_in};
            drain_reg <= drain;
        end
    end

    bb3_line_store #(
        .MAX_WIDTH (MAX_WIDTH),
        .CW        (CW)
    ) u_line_store (
        .clk       (clk),
        .rd_en     (item_ok),
        .wr_en     (state_reg == S_WIN && !drain_reg),
        .addr      (col_pos_reg),
        .wdata     (pix_reg),
        .upper_rd  (upper_rd),
        .middle_rd (middle_rd)
    );

    // Shift the window and record which results this position releases
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    win_reg[i][j] <= '0;
                end
            end
            emit_a_reg <= 1'b0;
            emit_b_reg <= 1'b0;
            top_ok_reg <= 1'b0;
            bot_ok_reg <= 1'b0;
            left2_reg  <= 1'b0;
            left1_reg  <= 1'b0;
            cur_b_reg  <= 1'b0;
        end
        else
        begin
            if (state_reg == S_WIN)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    win_reg[i][0] <= win_reg[i][1];
                    win_reg[i][1] <= win_reg[i][2];
                end
                win_reg[0][2] <= upper_rd;
                win_reg[1][2] <= middle_rd;
                win_reg[2][2] <= pix_reg;
                emit_a_reg    <= r_ge1 && c_ge1;
                emit_b_reg    <= r_ge1 && last_col;
                top_ok_reg    <= r_ge2;
                bot_ok_reg    <= !drain_reg;
                left2_reg     <= c_ge2;
                left1_reg     <= c_ge1;
            end
            if (state_reg == S_LOAD)
            begin
                cur_b_reg <= !emit_a_reg;
            end
            if (push)
            begin
                if (cur_b_reg)
                begin
                    emit_b_reg <= 1'b0;
                end
                else
                begin
                    emit_a_reg <= 1'b0;
                end
            end
        end
    end

    // Advance the frame position; a register write restarts the frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_pos_reg <= '0;
            row_pos_reg <= '0;
        end
        else if (cfg_wr)
        begin
            col_pos_reg <= '0;
            row_pos_reg <= '0;
        end
        else if (state_reg == S_WIN)
        begin
            if (last_col)
            begin
                col_pos_reg <= '0;
                row_pos_reg <= drain_reg ? '0 : row_pos_reg + HW'(1);
            end
            else
            begin
                col_pos_reg <= col_pos_reg + CW'(1);
            end
        end
    end

    // Neighbor mask: center in window column 1 first, then column 2 at row end
    assign row_m = {bot_ok_reg, 1'b1, top_ok_reg};
    assign col_m = emit_a_reg ? {1'b1, 1'b1, left2_reg} : {1'b1, left1_reg, 1'b0};

    always_comb
    begin
        lane_ctl.start = state_reg == S_LOAD;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                lane_ctl.mask[i*3+j] = row_m[i] && col_m[j];
            end
        end
    end

    // Red, green and blue lanes
    for (genvar ch = 0; ch < 3; ch++)
    begin : g_lane
        bb3_pkg::chan_win_t cwin;

        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    cwin[i*3+j] = win_reg[i][j][23-8*ch -: 8];
                end
            end
        end

        bb3_lane u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .ctl   (lane_ctl),
            .win   (cwin),
            .idle  (lane_idle[ch]),
            .quot  (lane_quot[ch])
        );
    end

    assign push = state_reg == S_PUSH && space;

    bb3_merge u_merge (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .quot           (lane_quot),
        .push_row_end   (cur_b_reg),
        .push_frame_end (cur_b_reg && drain_reg),
        .res_ready      (res_ready),
        .res_valid      (res_valid),
        .red_out        (red_out),
        .green_out      (green_out),
        .blue_out       (blue_out),
        .row_end        (row_end),
        .frame_end      (frame_end),
        .space          (space)
    );

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_ok)
                begin
                    state_next = S_WIN;
                end
            end
            S_WIN:
            begin
                state_next = (r_ge1 && (c_ge1 || last_col)) ? S_LOAD : S_IDLE;
            end
            S_LOAD:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (&lane_idle)
                begin
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                if (space)
                begin
                    state_next = (!cur_b_reg && emit_b_reg) ? S_LOAD : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: hdl/bb3_line_store.sv
// Two line buffers (rows r-2 and r-1) sharing one column address.
// Uses no package; instantiated by box_blur_3x3_stream.
module bb3_line_store #(
    parameter int MAX_WIDTH = 1024,
    parameter int CW        = 10
) (
    input  logic          clk,
    input  logic          rd_en,
    input  logic          wr_en,
    input  logic [CW-1:0] addr,
    input  logic [23:0]   wdata,
    output logic [23:0]   upper_rd,
    output logic [23:0]   middle_rd
);

    logic [23:0] upper_mem  [MAX_WIDTH];
    logic [23:0] middle_mem [MAX_WIDTH];
    logic [23:0] upper_rd_reg;
    logic [23:0] middle_rd_reg;

    // Read both rows at the column; data lands in the read registers
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            upper_rd_reg  <= upper_mem[addr];
            middle_rd_reg <= middle_mem[addr];
        end
    end

    // Move the old middle row up and store the new pixel
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            upper_mem[addr]  <= middle_rd_reg;
            middle_mem[addr] <= wdata;
        end
    end

    assign upper_rd  = upper_rd_reg;
    assign middle_rd = middle_rd_reg;

endmodule

FILE: hdl/bb3_lane.sv
// One color lane: masked 3x3 sum, then rounded mean by an 8-step restoring divide.
// Depends on bb3_pkg.
module bb3_lane (
    input  logic                clk,
    input  logic                rst_n,
    input  bb3_pkg::lane_ctl_t  ctl,
    input  bb3_pkg::chan_win_t  win,
    output logic                idle,
    output bb3_pkg::pix_t       quot
);

    bb3_pkg::sum_t  sum;
    bb3_pkg::cnt_t  cnt;
    bb3_pkg::divd_t dividend;
    bb3_pkg::divd_t shifted;
    logic           fits;

    bb3_pkg::divd_t rem_reg;
    bb3_pkg::divs_t div_reg;
    bb3_pkg::pix_t  quot_reg;
    bb3_pkg::step_t step_reg;
    logic           busy_reg;

    // Sum the neighbors that the mask keeps and count them
    always_comb
    begin
        sum = '0;
        cnt = '0;
        for (int k = 0; k < 9; k++)
        begin
            if (ctl.mask[k])
            begin
                sum = sum + bb3_pkg::sum_t'(win[k]);
                cnt = cnt + bb3_pkg::cnt_t'(1);
            end
        end
    end

    // Round half up: (2*sum + count) / (2*count), quotient below 256
    assign dividend = {sum, 1'b0} + bb3_pkg::divd_t'(cnt);
    assign shifted  = bb3_pkg::divd_t'(div_reg) << step_reg;
    assign fits     = rem_reg >= shifted;

    // Sequence the divide steps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (ctl.start)
        begin
            busy_reg <= 1'b1;
        end
        else if (busy_reg && step_reg == '0)
        begin
            busy_reg <= 1'b0;
        end
    end

    // Load the operands, then settle one quotient bit per cycle
    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            rem_reg  <= dividend;
            div_reg  <= {cnt, 1'b0};
            quot_reg <= '0;
            step_reg <= '1;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg            <= rem_reg - shifted;
                quot_reg[step_reg] <= 1'b1;
            end
            step_reg <= step_reg - bb3_pkg::step_t'(1);
        end
    end

    assign idle = !busy_reg;
    assign quot = quot_reg;

endmodule

FILE: hdl/bb3_merge.sv
// Merge stage: joins the three lane quotients and the row flags into one result register.
// Depends on bb3_pkg.
module bb3_merge (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  bb3_pkg::quot_set_t  quot,
    input  logic                push_row_end,
    input  logic                push_frame_end,
    input  logic                res_ready,
    output logic                res_valid,
    output logic [7:0]          red_out,
    output logic [7:0]          green_out,
    output logic [7:0]          blue_out,
    output logic                row_end,
    output logic                frame_end,
    output logic                space
);

    logic       valid_reg;
    logic [7:0] red_reg;
    logic [7:0] green_reg;
    logic [7:0] blue_reg;
    logic       row_end_reg;
    logic       frame_end_reg;

    // Room for a new result once the held one is taken
    assign space = !valid_reg || res_ready;

    // Track the held transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (push)
        begin
            valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Capture the lane results together
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            red_reg       <= quot[0];
            green_reg     <= quot[1];
            blue_reg      <= quot[2];
            row_end_reg   <= push_row_end;
            frame_end_reg <= push_frame_end;
        end
    end

    assign res_valid = valid_reg;
    assign red_out   = red_reg;
    assign green_out = green_reg;
    assign blue_out  = blue_reg;
    assign row_end   = row_end_reg;
    assign frame_end = frame_end_reg;

endmodule

FILE: hdl/bb3_checker.sv
// Port-level checker for box_blur_3x3_stream, bound to the top level.
// Depends on box_blur_3x3_stream_defines.svh.
`include "box_blur_3x3_stream_defines.svh"

module bb3_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        pix_ready,
    input logic        res_valid,
    input logic        res_ready,
    input logic [7:0]  red_out,
    input logic [7:0]  blue_out,
    input logic        row_end,
    input logic        frame_end
);

    // Hold a stalled result transaction
    `BB3_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(red_out), "stall")
    `BB3_ASSERT_NEXT(a_flag_hold, res_valid && !res_ready, $stable(row_end) && $stable(blue_out), "stall")

    // The frame's last result also closes its row
    `BB3_ASSERT_SAME(a_frame_row, res_valid && frame_end, row_end, "frame_end without row_end")

    // A new result never follows a cycle in which pixels were being taken
    `BB3_ASSERT_SAME(a_res_busy, $rose(res_valid), !$past(pix_ready), "result while accepting")

endmodule

bind box_blur_3x3_stream bb3_checker u_bb3_checker (.*);
